// ===== rtl/assert_macros.svh =====
// Assertion macros used by the RTL core of the buffer manager.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// The property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk_s, rstn_s, prop) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (prop)) \
    else $error("assertion failed");
// When the condition holds, the consequence must hold in the next cycle.
`define ASSERT_NEXT(lbl, clk_s, rstn_s, cond, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (cond) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, clk_s, rstn_s, prop)
`define ASSERT_NEXT(lbl, clk_s, rstn_s, cond, cons)
`endif
`endif

// ===== rtl/cabm_pkg.sv =====
// Package with request and status codes and sizes for the buffer manager.
`timescale 1ns / 1ps
package cabm_pkg;

  localparam int SLOTS_DEF  = 8;
  localparam int CNT_W      = 4;
  localparam int SLOT_IN_W  = 3;
  localparam int SLOT_OUT_W = 3;
  localparam logic [CNT_W-1:0] COUNT_MAX = 4'd15;

  typedef enum logic [1:0] {
    REQ_RESERVE = 2'd0,
    REQ_PUT     = 2'd1,
    REQ_GET     = 2'd2,
    REQ_UNGET   = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NO_FREE = 2'd1,
    ST_NO_MSG  = 2'd2,
    ST_LIMIT   = 2'd3
  } status_t;

endpackage

// ===== rtl/cabm_find_free.sv =====
// Lowest-set-bit finder that picks the first free slot.
`timescale 1ns / 1ps
module cabm_find_free
  import cabm_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEF,
  localparam int IDX_W = $clog2(SLOTS)
) (
  input  logic [SLOTS-1:0] free_vec,
  output logic             found,
  output logic [IDX_W-1:0] idx
);

  logic [SLOTS-1:0] lowest;

  // Isolate the lowest set bit, then encode the one-hot word.
  assign lowest = free_vec & (~free_vec + SLOTS'(1));
  assign found  = |free_vec;

  always_comb begin
    idx = '0;
    for (int i = 0; i < SLOTS; i++) begin
      idx = idx | ({IDX_W{lowest[i]}} & IDX_W'(i));
    end
  end

endmodule

// ===== rtl/cyclic_async_buffer_manager_core.sv =====
// Top level of the cyclic asynchronous buffer slot manager.
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Slot bookkeeping for a cyclic asynchronous buffer with one writer and
// several readers. Each request item (reserve, put, get or unget) yields
// exactly one result item. The block takes one item per clock cycle and
// each item is first held in the request register, after which the
// block reads the bank of per-slot use counts, updates one count or
// the most-recent-message register, and loads the result
// register. The reserve search is a parallel lowest-free-slot finder over
// all SLOTS counts, so the clock period is set by that finder and the
// count bank read. A stalled output holds its result while the request
// register takes the next item; when both are full the input stalls.
// Use counts saturate at 15 and 0 with a count-limit status, and a get
// before the first put reports that no message exists yet.
module cyclic_async_buffer_manager_core
  import cabm_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [2:0] slot_in, [7:3] zero
  input  logic [1:0] in_tuser,   // [1:0] req_type
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [2:0] slot_out, [6:3] use_count_out, [7] zero
  output logic [1:0] out_tuser   // [1:0] status
);

  localparam int IDX_W = $clog2(SLOTS);

  // Request register.
  logic                 st_vld_r, st_vld_nxt;
  req_t                 st_req_r;
  logic [SLOT_IN_W-1:0] st_slot_r;

  // Slot state.
  logic [CNT_W-1:0] cnt_r   [SLOTS];
  logic [CNT_W-1:0] cnt_nxt [SLOTS];
  logic [IDX_W-1:0] lat_slot_r, lat_slot_nxt;
  logic             lat_valid_r, lat_valid_nxt;

  // Result register.
  logic                  out_valid_r, out_valid_nxt;
  logic [SLOT_OUT_W-1:0] res_slot_r, res_slot;
  status_t               res_st_r, res_st;
  logic [CNT_W-1:0]      res_cnt_r, res_cnt;

  logic             adv;
  logic             in_range;
  logic [IDX_W-1:0] sidx;
  logic [SLOTS-1:0] free_vec;
  logic             found;
  logic [IDX_W-1:0] fidx;
  logic [CNT_W-1:0] c_lat, c_sel;

  // The result register can take a new result when empty or being drained.
  assign adv       = !out_valid_r || out_tready;
  assign in_tready = !st_vld_r || adv;

  always_comb begin
    st_vld_nxt = st_vld_r;
    if (in_tready) begin
      st_vld_nxt = in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_vld_r <= 1'b0;
    end else begin
      st_vld_r <= st_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      st_req_r  <= req_t'(in_tuser);
      st_slot_r <= in_tdata[SLOT_IN_W-1:0];
    end
  end

  // A slot is free when nobody uses it and it is not the current message.
  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      free_vec[i] = (cnt_r[i] == '0) && !(lat_valid_r && (lat_slot_r == IDX_W'(i)));
    end
  end

  cabm_find_free #(
    .SLOTS (SLOTS)
  ) u_find_free (
    .free_vec (free_vec),
    .found    (found),
    .idx      (fidx)
  );

  assign in_range = (32'(st_slot_r) < SLOTS);
  assign sidx     = IDX_W'(st_slot_r);
  assign c_lat    = cnt_r[lat_slot_r];
  assign c_sel    = cnt_r[sidx];

  always_comb begin
    cnt_nxt       = cnt_r;
    lat_slot_nxt  = lat_slot_r;
    lat_valid_nxt = lat_valid_r;
    res_slot      = '0;
    res_st        = ST_OK;
    res_cnt       = '0;
    out_valid_nxt = out_valid_r;
    if (adv) begin
      out_valid_nxt = st_vld_r;
    end
    if (st_vld_r && adv) begin
      unique case (st_req_r)
        REQ_RESERVE: begin
          if (found) begin
            cnt_nxt[fidx] = CNT_W'(1);
            res_slot      = SLOT_OUT_W'(fidx);
            res_cnt       = CNT_W'(1);
          end else begin
            res_st = ST_NO_FREE;
          end
        end
        REQ_GET: begin
          if (!lat_valid_r) begin
            res_st = ST_NO_MSG;
          end else if (c_lat == COUNT_MAX) begin
            res_slot = SLOT_OUT_W'(lat_slot_r);
            res_st   = ST_LIMIT;
            res_cnt  = COUNT_MAX;
          end else begin
            cnt_nxt[lat_slot_r] = c_lat + CNT_W'(1);
            res_slot            = SLOT_OUT_W'(lat_slot_r);
            res_cnt             = c_lat + CNT_W'(1);
          end
        end
        REQ_PUT: begin
          res_slot = SLOT_OUT_W'(st_slot_r);
          if (!in_range) begin
            res_st = ST_LIMIT;
          end else begin
            lat_slot_nxt  = sidx;
            lat_valid_nxt = 1'b1;
            cnt_nxt[sidx] = '0;
          end
        end
        REQ_UNGET: begin
          res_slot = SLOT_OUT_W'(st_slot_r);
          if (!in_range || (c_sel == '0)) begin
            res_st = ST_LIMIT;
          end else begin
            cnt_nxt[sidx] = c_sel - CNT_W'(1);
            res_cnt       = c_sel - CNT_W'(1);
          end
        end
        default: begin
          res_st = ST_LIMIT;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) begin
        cnt_r[i] <= '0;
      end
      lat_slot_r  <= '0;
      lat_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      lat_slot_r  <= lat_slot_nxt;
      lat_valid_r <= lat_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (st_vld_r && adv) begin
      res_slot_r <= res_slot;
      res_st_r   <= res_st;
      res_cnt_r  <= res_cnt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, res_cnt_r, res_slot_r};
  assign out_tuser  = res_st_r;

  // Once a message exists it never disappears.
  `ASSERT_NEXT(a_latest_sticky, clk, rst_n, lat_valid_r, lat_valid_r)
  // The current message always names an existing slot.
  `ASSERT_ALWAYS(a_latest_range, clk, rst_n, !lat_valid_r || (32'(lat_slot_r) < SLOTS))
  // A request that moves on always produces a result in the next cycle.
  `ASSERT_NEXT(a_result_follows, clk, rst_n, st_vld_r && adv, out_valid_r)
  // A failed reserve or a get without a message reports slot and count zero.
  `ASSERT_ALWAYS(a_empty_result, clk, rst_n,
    !(out_valid_r && (res_st_r == ST_NO_FREE || res_st_r == ST_NO_MSG)) ||
    (res_slot_r == '0 && res_cnt_r == '0))

endmodule
